// ===== rtl/mal_pkg.sv =====
// ----------------------------------------------------------------------------
// mal_pkg
// shared types, codes and constants of the mac access list text loader
// ----------------------------------------------------------------------------
package mal_pkg;

   localparam int MAX_ENTRIES_DEF = 256;
   localparam int MAC_W           = 48;
   localparam int LINE_MAX        = 17;
   localparam int LEN_W           = 5;
   localparam int KW_COUNT        = 3;

   localparam logic [15:0] BUDGET_RST = 16'd51200;

   localparam logic [1:0] REQ_CHAR  = 2'd0;
   localparam logic [1:0] REQ_END   = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;
   localparam logic [1:0] REQ_NOP   = 2'd3;

   localparam logic [2:0] EV_STORED  = 3'd0;
   localparam logic [2:0] EV_MODE    = 3'd1;
   localparam logic [2:0] EV_FULL    = 3'd2;
   localparam logic [2:0] EV_END     = 3'd3;
   localparam logic [2:0] EV_INVALID = 3'd4;
   localparam logic [2:0] EV_BUDGET  = 3'd5;
   localparam logic [2:0] EV_NONE    = 3'd7;

   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LC_A  = 8'd97;
   localparam logic [7:0] CH_LC_Z  = 8'd122;
   localparam logic [7:0] CH_CASE  = 8'd32;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_UC_F  = 8'h46;
   localparam logic [7:0] CH_HEX_A = 8'd55;

   // keyword text, index equals the mode code: off, allow, deny
   localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
      '{8'h4F, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h41, 8'h4C, 8'h4C, 8'h4F, 8'h57, 8'h00, 8'h00, 8'h00},
      '{8'h44, 8'h45, 8'h4E, 8'h59, 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{5'd3, 5'd5, 5'd4};

   typedef struct packed {
      logic       push;
      logic       clr_line;
      logic       clr_comment;
      logic [7:0] ch;
   } mal_scan_ctl_type;

   typedef struct packed {
      logic             nonempty;
      logic             kw_hit;
      logic [1:0]       kw_mode;
      logic             mac_ok;
      logic [MAC_W-1:0] mac;
   } mal_scan_stat_type;

   typedef struct packed {
      logic done;
      logic found;
   } mal_srch_stat_type;

endpackage

// ===== rtl/mac_acl_text_loader_unit.sv =====
// ----------------------------------------------------------------------------
// mac_acl_text_loader_unit
// loads a mac access list from text, one character word at a time
// ----------------------------------------------------------------------------
// A character or end marker that gives no result leaves the unit idle. A word
// that gives a result is held in the pending registers until the emit state
// moves it to the output register; that state waits while the output register
// is still stalled. A line that ends in a valid mac address runs a duplicate
// search over the stored table through one ram read port and one 48-bit
// comparator, one entry per cycle. The request stall is high while a word is in
// work. The table needs no clearing pass after reset.
module mac_acl_text_loader_unit
   import mal_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_char_code,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_code,
   output logic [7:0]  rsp_entry_slot,
   output logic [47:0] rsp_mac_value,
   output logic [1:0]  rsp_list_mode,
   output logic [8:0]  rsp_entry_total
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SRCH = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [15:0]      budget_ff, budget_in;
   logic [15:0]      count_ff, count_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [1:0]       mode_ff, mode_in;
   logic             finished_ff, finished_in;
   logic             last_ff, last_in;
   logic [2:0]       pev_ff, pev_in;
   logic [7:0]       pslot_ff, pslot_in;
   logic [MAC_W-1:0] pmac_ff, pmac_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_ev_ff, rsp_ev_in;
   logic [7:0]       rsp_slot_ff, rsp_slot_in;
   logic [MAC_W-1:0] rsp_mac_ff, rsp_mac_in;
   logic [1:0]       rsp_mode_ff, rsp_mode_in;
   logic [8:0]       rsp_total_ff, rsp_total_in;

   mal_scan_ctl_type  scan_ctl;
   mal_scan_stat_type scan_stat;
   mal_srch_stat_type srch_stat;
   logic              srch_start;

   logic              fire;
   logic              last_now;
   logic [2:0]        ev;
   logic              fin;
   logic              out_free;
   logic [CNT_W-1:0]  total_next;

   mal_line_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .stat  (scan_stat)
   );

   mal_dup_search #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_search (
      .clock (clock),
      .reset (reset),
      .start (srch_start),
      .key   (scan_stat.mac),
      .total (total_ff),
      .stat  (srch_stat)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign fire = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_now = ({1'b0, count_ff} + 17'd1) >= {1'b0, budget_ff};
   assign total_next = total_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      budget_in = csr_wr_en ? csr_wr_data : budget_ff;
      count_in = count_ff;
      total_in = total_ff;
      mode_in = mode_ff;
      finished_in = finished_ff;
      last_in = last_ff;
      pev_in = pev_ff;
      pslot_in = pslot_ff;
      pmac_in = pmac_ff;
      scan_ctl = '0;
      scan_ctl.ch = req_char_code;
      srch_start = 1'b0;
      ev = EV_NONE;
      fin = 1'b0;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ev_in = rsp_ev_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_mac_in = rsp_mac_ff;
      rsp_mode_in = rsp_mode_ff;
      rsp_total_in = rsp_total_ff;

      unique case (state_ff)
         ST_IDLE: begin
            pslot_in = 8'd0;
            pmac_in = '0;
            if (fire) begin
               if (req_type == REQ_START) begin
                  scan_ctl.clr_line = 1'b1;
                  scan_ctl.clr_comment = 1'b1;
                  total_in = '0;
                  count_in = 16'd0;
                  finished_in = 1'b0;
               end else if (req_type != REQ_NOP && !finished_ff) begin
                  if (count_ff >= budget_ff) begin
                     finished_in = 1'b1;
                     pev_in = EV_BUDGET;
                     state_in = ST_EMIT;
                  end else begin
                     count_in = count_ff + 16'd1;
                     if (req_type == REQ_END) begin
                        scan_ctl.clr_comment = 1'b1;
                        fin = 1'b1;
                        ev = EV_END;
                     end else if (req_char_code == CH_LF || req_char_code == CH_CR) begin
                        scan_ctl.clr_line = 1'b1;
                        scan_ctl.clr_comment = 1'b1;
                        if (scan_stat.nonempty) begin
                           if (scan_stat.kw_hit) begin
                              mode_in = scan_stat.kw_mode;
                              ev = EV_MODE;
                           end else if (!scan_stat.mac_ok) begin
                              fin = 1'b1;
                              ev = EV_INVALID;
                           end else begin
                              srch_start = 1'b1;
                           end
                        end
                     end else begin
                        scan_ctl.push = 1'b1;
                     end

                     if (srch_start) begin
                        last_in = last_now;
                        state_in = ST_SRCH;
                     end else begin
                        if (!fin && last_now) begin
                           fin = 1'b1;
                           ev = EV_BUDGET;
                        end
                        finished_in = fin;
                        if (ev != EV_NONE) begin
                           pev_in = ev;
                           state_in = ST_EMIT;
                        end
                     end
                  end
               end
            end
         end
         ST_SRCH: begin
            if (srch_stat.done) begin
               if (srch_stat.found) begin
                  pslot_in = 8'd0;
                  pmac_in = '0;
               end else begin
                  pslot_in = 8'(total_ff);
                  pmac_in = scan_stat.mac;
                  total_in = total_next;
                  if (total_next == CNT_W'(MAX_ENTRIES)) begin
                     fin = 1'b1;
                     ev = EV_FULL;
                  end else begin
                     ev = EV_STORED;
                  end
               end
               if (!fin && last_ff) begin
                  fin = 1'b1;
                  ev = EV_BUDGET;
               end
               finished_in = fin;
               pev_in = ev;
               state_in = (ev != EV_NONE) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ev_in = pev_ff;
               rsp_slot_in = pslot_ff;
               rsp_mac_in = pmac_ff;
               rsp_mode_in = mode_ff;
               rsp_total_in = 9'(total_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         budget_ff <= BUDGET_RST;
         count_ff <= 16'd0;
         total_ff <= '0;
         mode_ff <= 2'd0;
         finished_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         budget_ff <= budget_in;
         count_ff <= count_in;
         total_ff <= total_in;
         mode_ff <= mode_in;
         finished_ff <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff <= last_in;
      pev_ff <= pev_in;
      pslot_ff <= pslot_in;
      pmac_ff <= pmac_in;
      rsp_ev_ff <= rsp_ev_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_mac_ff <= rsp_mac_in;
      rsp_mode_ff <= rsp_mode_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_event_code = rsp_ev_ff;
   assign rsp_entry_slot = rsp_slot_ff;
   assign rsp_mac_value = rsp_mac_ff;
   assign rsp_list_mode = rsp_mode_ff;
   assign rsp_entry_total = rsp_total_ff;

endmodule

// ===== rtl/mal_ram.sv =====
// ----------------------------------------------------------------------------
// mal_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module mal_ram
   import mal_pkg::*;
#(
   parameter int WIDTH = MAC_W,
   parameter int DEPTH = MAX_ENTRIES_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mal_line_scan.sv =====
// ----------------------------------------------------------------------------
// mal_line_scan
// per character line parser: keyword match, mac format check and packing
// ----------------------------------------------------------------------------
module mal_line_scan
   import mal_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mal_scan_ctl_type  ctl,
   output mal_scan_stat_type stat
);

   logic [LEN_W-1:0]    len_ff, len_in;
   logic [1:0]          col_ff, col_in;
   logic                comment_ff, comment_in;
   logic                fmt_ok_ff, fmt_ok_in;
   logic [KW_COUNT-1:0] kw_ok_ff, kw_ok_in;
   logic [MAC_W-1:0]    acc_ff, acc_in;

   logic [7:0] ch_a;
   logic [7:0] ch_u;
   logic       com_set;
   logic       keep;
   logic       is_hex;
   logic [7:0] nib_wide;
   logic       colon_pos;

   always_comb begin
      ch_a = (ctl.ch == CH_DASH) ? CH_COLON : ctl.ch;
      ch_u = (ch_a >= CH_LC_A && ch_a <= CH_LC_Z) ? ch_a - CH_CASE : ch_a;
      com_set = comment_ff | (ctl.ch == CH_SEMI);
      keep = ctl.push && !com_set && (ch_u != CH_SPACE) && (len_ff < LEN_W'(LINE_MAX));
      colon_pos = (col_ff == 2'd2);
      if (ch_u >= CH_0 && ch_u <= CH_9) begin
         is_hex = 1'b1;
         nib_wide = ch_u - CH_0;
      end else if (ch_u >= CH_UC_A && ch_u <= CH_UC_F) begin
         is_hex = 1'b1;
         nib_wide = ch_u - CH_HEX_A;
      end else begin
         is_hex = 1'b0;
         nib_wide = 8'd0;
      end

      len_in = len_ff;
      col_in = col_ff;
      fmt_ok_in = fmt_ok_ff;
      kw_ok_in = kw_ok_ff;
      acc_in = acc_ff;
      comment_in = comment_ff;

      if (ctl.clr_comment) begin
         comment_in = 1'b0;
      end else if (ctl.push) begin
         comment_in = com_set;
      end

      if (ctl.clr_line) begin
         len_in = '0;
         col_in = 2'd0;
         fmt_ok_in = 1'b1;
         kw_ok_in = '1;
      end else if (keep) begin
         len_in = len_ff + 1'b1;
         col_in = colon_pos ? 2'd0 : col_ff + 1'b1;
         fmt_ok_in = fmt_ok_ff & (colon_pos ? (ch_u == CH_COLON) : is_hex);
         if (!colon_pos && is_hex) begin
            acc_in = {acc_ff[MAC_W-5:0], nib_wide[3:0]};
         end
         for (int k = 0; k < KW_COUNT; k++) begin
            kw_ok_in[k] = kw_ok_ff[k] & (len_ff < KW_LEN[k]) &
                          (ch_u == KW_TEXT[k][len_ff[2:0]]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         col_ff <= 2'd0;
         comment_ff <= 1'b0;
         fmt_ok_ff <= 1'b1;
         kw_ok_ff <= '1;
      end else begin
         len_ff <= len_in;
         col_ff <= col_in;
         comment_ff <= comment_in;
         fmt_ok_ff <= fmt_ok_in;
         kw_ok_ff <= kw_ok_in;
      end
      acc_ff <= acc_in;
   end

   always_comb begin
      stat.nonempty = (len_ff != '0);
      stat.kw_hit = 1'b0;
      stat.kw_mode = 2'd0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (kw_ok_ff[k] && len_ff == KW_LEN[k]) begin
            stat.kw_hit = 1'b1;
            stat.kw_mode = 2'(k);
         end
      end
      stat.mac_ok = fmt_ok_ff && (len_ff == LEN_W'(LINE_MAX)) && !acc_ff[40];
      stat.mac = acc_ff;
   end

endmodule

// ===== rtl/mal_dup_search.sv =====
// ----------------------------------------------------------------------------
// mal_dup_search
// walks the stored table one entry a cycle with a single comparator and
// appends the key when no match is found and the table is not full
// ----------------------------------------------------------------------------
module mal_dup_search
   import mal_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MAC_W-1:0]  key,
   input  logic [CNT_W-1:0]  total,
   output mal_srch_stat_type stat
);

   logic             busy_ff, busy_in;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic [MAC_W-1:0] key_ff, key_in;

   logic [MAC_W-1:0] rd_data;
   logic             wr_en;
   logic             hit;

   mal_ram #(
      .WIDTH (MAC_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (total[IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_addr (iss_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      busy_in = busy_ff;
      pend_in = pend_ff;
      iss_in = iss_ff;
      key_in = key_ff;
      wr_en = 1'b0;
      stat.done = 1'b0;
      stat.found = 1'b0;
      hit = pend_ff && (rd_data == key_ff);

      if (start) begin
         busy_in = 1'b1;
         pend_in = 1'b0;
         iss_in = '0;
         key_in = key;
      end else if (busy_ff) begin
         if (hit) begin
            stat.done = 1'b1;
            stat.found = 1'b1;
            busy_in = 1'b0;
            pend_in = 1'b0;
         end else if (iss_ff < total) begin
            iss_in = iss_ff + 1'b1;
            pend_in = 1'b1;
         end else begin
            stat.done = 1'b1;
            wr_en = (total < CNT_W'(MAX_ENTRIES));
            stat.found = !wr_en;
            busy_in = 1'b0;
            pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         iss_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         iss_ff <= iss_in;
      end
      key_ff <= key_in;
   end

endmodule
